// ===== rtl/prc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_pkg: shared types and microprogram for the primitive root counter
// Holds the control word layout, the jump condition codes, the step numbers
// and the read-only microprogram that drives the counter datapath.
// ----------------------------------------------------------------------------
package prc_pkg;

	localparam int PC_W = 4;

	// Jump condition codes
	localparam logic [2:0] C_ALWAYS    = 3'd0;
	localparam logic [2:0] C_NOT_VALID = 3'd1;
	localparam logic [2:0] C_N_SMALL   = 3'd2;
	localparam logic [2:0] C_BIT_MORE  = 3'd3;
	localparam logic [2:0] C_P_ONE     = 3'd4;
	localparam logic [2:0] C_J_MORE    = 3'd5;
	localparam logic [2:0] C_G_MORE    = 3'd6;
	localparam logic [2:0] C_OUT_BUSY  = 3'd7;

	// Microprogram step numbers
	localparam logic [PC_W-1:0] S_IDLE     = 4'd0;
	localparam logic [PC_W-1:0] S_CHK_N    = 4'd1;
	localparam logic [PC_W-1:0] S_G_INIT   = 4'd2;
	localparam logic [PC_W-1:0] S_MUL_INIT = 4'd3;
	localparam logic [PC_W-1:0] S_MUL_STEP = 4'd4;
	localparam logic [PC_W-1:0] S_CHECK_P  = 4'd5;
	localparam logic [PC_W-1:0] S_CHECK_J  = 4'd6;
	localparam logic [PC_W-1:0] S_NO_ORDER = 4'd7;
	localparam logic [PC_W-1:0] S_ORDER    = 4'd8;
	localparam logic [PC_W-1:0] S_NEXT_G   = 4'd9;
	localparam logic [PC_W-1:0] S_DONE     = 4'd10;
	localparam logic [PC_W-1:0] S_RET      = 4'd11;

	// One control word per step
	typedef struct packed {
		logic [2:0]      cond;     // jump when true, else fall through
		logic [PC_W-1:0] target;
		logic            ld_n;     // take request, g=1, count=0
		logic            p_init;   // p=1, j=1
		logic            acc_clr;  // acc=0, bit=MSB
		logic            mul_step; // one shift-add-reduce step
		logic            st_p;     // p=acc
		logic            inc_j;
		logic            inc_cnt;  // count a root when order is n-1
		logic            inc_g;
		logic            ld_out;
	} ctrl_t;

	function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
		ctrl_t cw;
		cw = '0;
		cw.cond   = C_ALWAYS;
		cw.target = S_IDLE;
		case (pc)
			S_IDLE: begin
				cw.ld_n   = 1'b1;
				cw.cond   = C_NOT_VALID;
				cw.target = S_IDLE;
			end
			S_CHK_N: begin
				cw.cond   = C_N_SMALL;
				cw.target = S_DONE;
			end
			S_G_INIT: begin
				cw.p_init = 1'b1;
				cw.cond   = C_ALWAYS;
				cw.target = S_MUL_INIT;
			end
			S_MUL_INIT: begin
				cw.acc_clr = 1'b1;
				cw.cond    = C_ALWAYS;
				cw.target  = S_MUL_STEP;
			end
			S_MUL_STEP: begin
				cw.mul_step = 1'b1;
				cw.cond     = C_BIT_MORE;
				cw.target   = S_MUL_STEP;
			end
			S_CHECK_P: begin
				cw.st_p   = 1'b1;
				cw.cond   = C_P_ONE;
				cw.target = S_ORDER;
			end
			S_CHECK_J: begin
				cw.inc_j  = 1'b1;
				cw.cond   = C_J_MORE;
				cw.target = S_MUL_INIT;
			end
			S_NO_ORDER: begin
				cw.cond   = C_ALWAYS;
				cw.target = S_NEXT_G;
			end
			S_ORDER: begin
				cw.inc_cnt = 1'b1;
				cw.cond    = C_ALWAYS;
				cw.target  = S_NEXT_G;
			end
			S_NEXT_G: begin
				cw.inc_g  = 1'b1;
				cw.cond   = C_G_MORE;
				cw.target = S_G_INIT;
			end
			S_DONE: begin
				cw.ld_out = 1'b1;
				cw.cond   = C_OUT_BUSY;
				cw.target = S_DONE;
			end
			S_RET: begin
				cw.cond   = C_ALWAYS;
				cw.target = S_IDLE;
			end
			default: begin
				cw.cond   = C_ALWAYS;
				cw.target = S_IDLE;
			end
		endcase
		return cw;
	endfunction

endpackage

// ===== rtl/primitive_root_counter.sv =====
`timescale 1ns / 1ps
// Each power of g comes from the single shift-add modular multiplier, one multiplier bit per
// cycle; g stops once its power reaches 1 or its exponent reaches n-1. Moduli 1 and 0 skip the loop.
// One request at a time; once the result is loaded the program passes through S_RET back to
// S_IDLE, where the next request is taken.
// Reset clears the step counter and the output valid; no result is pending after reset.
// ----------------------------------------------------------------------------
// primitive_root_counter: brute-force primitive root count modulo n
// A microcoded sequencer walks every g in 1..n-1, builds powers of g one
// modular multiply at a time and counts those whose order is n-1.
// ----------------------------------------------------------------------------
module primitive_root_counter #(
	parameter int MODULUS_BITS = 11
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    modulus_valid,
	output logic                    modulus_stall,
	input  logic [MODULUS_BITS-1:0] modulus,
	output logic                    root_count_valid,
	input  logic                    root_count_stall,
	output logic [MODULUS_BITS-1:0] root_count
);
	import prc_pkg::*;

	localparam int W     = MODULUS_BITS;
	localparam int BIT_W = (W > 1) ? $clog2(W) : 1;

	logic [PC_W-1:0]  pc_q, pc_d;
	ctrl_t            cw;
	logic             take_jump;

	logic [W-1:0]     n_q, g_q, p_q, j_q, acc_q, cnt_q;
	logic [BIT_W-1:0] bit_q;
	logic [W-1:0]     root_count_q;
	logic             root_count_valid_q;

	logic [W-1:0]     nm1;
	logic             in_take, out_busy;
	logic [W:0]       dbl, dbl_red, sum, sum_red;

	assign cw      = ucode(pc_q);
	assign nm1     = n_q - W'(1);
	assign in_take = modulus_valid && !modulus_stall;
	assign out_busy = root_count_valid_q && root_count_stall;

	assign modulus_stall    = (pc_q != S_IDLE);
	assign root_count_valid = root_count_valid_q;
	assign root_count       = root_count_q;

	// Jump condition select
	always_comb begin
		case (cw.cond)
			C_ALWAYS:    take_jump = 1'b1;
			C_NOT_VALID: take_jump = !modulus_valid;
			C_N_SMALL:   take_jump = (n_q < W'(2));
			C_BIT_MORE:  take_jump = (bit_q != '0);
			C_P_ONE:     take_jump = (acc_q == W'(1));
			C_J_MORE:    take_jump = (j_q != nm1);
			C_G_MORE:    take_jump = (g_q != nm1);
			C_OUT_BUSY:  take_jump = out_busy;
			default:     take_jump = 1'b1;
		endcase
		pc_d = take_jump ? cw.target : pc_q + PC_W'(1);
	end

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

	// Modular multiply step: acc = 2*acc + bit*p, reduced mod n
	always_comb begin
		dbl     = {acc_q, 1'b0};
		dbl_red = (dbl >= {1'b0, n_q}) ? dbl - {1'b0, n_q} : dbl;
		sum     = dbl_red + (g_q[bit_q] ? {1'b0, p_q} : '0);
		sum_red = (sum >= {1'b0, n_q}) ? sum - {1'b0, n_q} : sum;
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (cw.ld_n && in_take) begin
			n_q   <= modulus;
			g_q   <= W'(1);
			cnt_q <= '0;
		end
		if (cw.p_init) begin
			p_q <= W'(1);
			j_q <= W'(1);
		end
		if (cw.acc_clr) begin
			acc_q <= '0;
			bit_q <= BIT_W'(W - 1);
		end
		if (cw.mul_step) begin
			acc_q <= sum_red[W-1:0];
			bit_q <= bit_q - BIT_W'(1);
		end
		if (cw.st_p) begin
			p_q <= acc_q;
		end
		if (cw.inc_j) begin
			j_q <= j_q + W'(1);
		end
		if (cw.inc_cnt && (j_q == nm1)) begin
			cnt_q <= cnt_q + W'(1);
		end
		if (cw.inc_g) begin
			g_q <= g_q + W'(1);
		end
		if (cw.ld_out && !out_busy) begin
			root_count_q <= cnt_q;
		end
	end

	// Output valid: a new load wins over the drain of the old result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_count_valid_q <= 1'b0;
		end else begin
			if (cw.ld_out && !out_busy) begin
				root_count_valid_q <= 1'b1;
			end else if (root_count_valid_q && !root_count_stall) begin
				root_count_valid_q <= 1'b0;
			end
		end
	end

	// Checks
	a_acc_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == S_MUL_STEP) |-> (acc_q < n_q))
		else $error("multiplier accumulator not reduced");

	a_p_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == S_MUL_STEP) |-> (p_q < n_q))
		else $error("power out of range");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == S_NEXT_G) |-> (cnt_q <= g_q))
		else $error("root count exceeds candidates tried");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> (pc_q == S_CHK_N))
		else $error("accepted request did not start the program");

	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(root_count_valid_q) |-> ($past(pc_q) == S_DONE))
		else $error("result valid raised outside the done step");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for primitive_root_counter
// Offers moduli over the valid/stall request channel and checks every root_count
// against a hand-typed count or a brute-force order search. A table of edge
// cases comes first, followed by a burst against a blocked output and then
// random small moduli under three idling patterns.
// ----------------------------------------------------------------------------
module testbench;

	localparam int MODULUS_BITS = 11;
	localparam int RESET_CYCLES = 6;
	localparam int HOLD_OFF_CYCLES = 4000;
	localparam int BURST_REQUESTS = 6;
	localparam int RANDOM_PER_PHASE = 24;
	localparam int DRAIN_CYCLES = 500;
	// the watchdog limit is sized for the largest directed modulus (1051)
	localparam int unsigned WATCHDOG_LIMIT = 30_000_000;
	localparam int REPORT_LIMIT = 10;

	typedef logic [MODULUS_BITS-1:0] modulus_t;

	// one directed row; known rows carry a hand-typed root count
	typedef struct packed {
		modulus_t modulus;
		logic     known;
		modulus_t root_count;
	} directed_row_t;

	typedef struct {
		modulus_t modulus;
		modulus_t root_count;
	} pending_count_t;

	logic     clk;
	logic     arst_n;
	logic     modulus_valid;
	logic     modulus_stall;
	modulus_t modulus;
	logic     root_count_valid;
	logic     root_count_stall;
	modulus_t root_count;

	pending_count_t pending_root_counts[$];

	int sender_idle_pct;
	int receiver_idle_pct;
	int hold_off_left;
	int mismatch_count;
	int results_checked;
	int moduli_offered;
	int max_modulus_offered;

	// zero/one/two, small primes, composites, prime powers, and the high bits
	directed_row_t directed_rows [22] = '{
		'{11'd0,    1'b1, 11'd0},
		'{11'd1,    1'b1, 11'd0},
		'{11'd2,    1'b1, 11'd1},
		'{11'd3,    1'b1, 11'd1},
		'{11'd5,    1'b1, 11'd2},
		'{11'd4,    1'b0, 11'd0},
		'{11'd6,    1'b0, 11'd0},
		'{11'd7,    1'b0, 11'd0},
		'{11'd8,    1'b0, 11'd0},
		'{11'd9,    1'b0, 11'd0},
		'{11'd12,   1'b0, 11'd0},
		'{11'd13,   1'b0, 11'd0},
		'{11'd16,   1'b0, 11'd0},
		'{11'd25,   1'b0, 11'd0},
		'{11'd31,   1'b0, 11'd0},
		'{11'd32,   1'b0, 11'd0},
		'{11'd63,   1'b0, 11'd0},
		'{11'd64,   1'b0, 11'd0},
		'{11'd97,   1'b0, 11'd0},
		'{11'd433,  1'b0, 11'd0},
		'{11'd577,  1'b0, 11'd0},
		'{11'd1051, 1'b0, 11'd0}
	};

	primitive_root_counter #(
		.MODULUS_BITS(MODULUS_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.modulus_valid(modulus_valid),
		.modulus_stall(modulus_stall),
		.modulus(modulus),
		.root_count_valid(root_count_valid),
		.root_count_stall(root_count_stall),
		.root_count(root_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// count residues 1..n-1 whose multiplicative order is exactly n-1
	function automatic modulus_t count_primitive_roots(input modulus_t n);
		int unsigned modv;
		int unsigned power;
		int unsigned order;
		int unsigned roots;
		modv = n;
		roots = 0;
		for (int unsigned g = 1; g < modv; g++) begin
			power = 1;
			order = 0;
			for (int unsigned j = 1; j < modv; j++) begin
				power = (power * g) % modv;
				if (power == 1) begin
					order = j;
					break;
				end
			end
			if (order == modv - 1)
				roots++;
		end
		return roots[MODULUS_BITS-1:0];
	endfunction

	task automatic note_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("[%0t] MISMATCH %s", $realtime, what);
	endtask

	// offer one request; returns at the rising edge that accepts it
	task automatic offer_modulus(input modulus_t n, input modulus_t count);
		pending_count_t entry;
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			modulus_valid <= 1'b0;
			modulus <= modulus_t'($urandom);
			@(negedge clk);
		end
		modulus_valid <= 1'b1;
		modulus <= n;
		do
			@(posedge clk);
		while (!(modulus_valid && !modulus_stall));
		entry.modulus = n;
		entry.root_count = count;
		pending_root_counts.insert(pending_root_counts.size(), entry);
		moduli_offered++;
		if (n > max_modulus_offered)
			max_modulus_offered = n;
	endtask

	// result side stall: long hold-off first when asked, else random
	initial begin
		root_count_stall = 1'b1;
		forever begin
			@(negedge clk);
			if (hold_off_left > 0) begin
				root_count_stall <= 1'b1;
				hold_off_left--;
			end else begin
				root_count_stall <= ($urandom_range(99) < receiver_idle_pct);
			end
		end
	end

	// compare each accepted result with the oldest pending count
	initial begin
		pending_count_t want;
		forever begin
			@(posedge clk);
			if (arst_n && root_count_valid && !root_count_stall) begin
				results_checked++;
				if (pending_root_counts.size() == 0) begin
					note_mismatch($sformatf("root_count %0d with no request pending",
						root_count));
				end else begin
					want = pending_root_counts.pop_front();
					if (root_count !== want.root_count)
						note_mismatch($sformatf("modulus %0d: root_count expected %0d got %0d",
							want.modulus, want.root_count, root_count));
				end
			end
		end
	end

	// watchdog: cycles with no handshake on either channel
	initial begin
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((modulus_valid && !modulus_stall) || (root_count_valid && !root_count_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("[%0t] watchdog expired, %0d requests still pending", $realtime,
			pending_root_counts.size());
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		modulus_t n;
		modulus_t count;
		arst_n = 1'b0;
		modulus_valid = 1'b0;
		modulus = '0;
		sender_idle_pct = 22;
		receiver_idle_pct = 57;
		hold_off_left = 0;
		mismatch_count = 0;
		results_checked = 0;
		moduli_offered = 0;
		max_modulus_offered = 0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// directed table
		foreach (directed_rows[i]) begin
			n = directed_rows[i].modulus;
			count = directed_rows[i].known ? directed_rows[i].root_count
				: count_primitive_roots(n);
			offer_modulus(n, count);
		end

		// block the output while small requests keep coming
		hold_off_left = HOLD_OFF_CYCLES;
		repeat (BURST_REQUESTS) begin
			n = modulus_t'($urandom_range(12, 2));
			offer_modulus(n, count_primitive_roots(n));
		end

		// random moduli: mostly tiny, some medium; cost grows with n squared
		for (int phase = 0; phase < 3; phase++) begin
			sender_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 57 : 0;
			receiver_idle_pct = (phase == 0) ? 57 : (phase == 1) ? 22 : 0;
			repeat (RANDOM_PER_PHASE) begin
				if ($urandom_range(99) < 10)
					n = modulus_t'($urandom_range(80, 41));
				else
					n = modulus_t'($urandom_range(40, 0));
				offer_modulus(n, count_primitive_roots(n));
			end
		end
		@(negedge clk);
		modulus_valid <= 1'b0;

		// drain, then watch for stray results
		while (pending_root_counts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d moduli: %0d table rows, %0d under a blocked output, %0d random;",
			moduli_offered, $size(directed_rows), BURST_REQUESTS, 3 * RANDOM_PER_PHASE);
		$display("largest modulus %0d, %0d root counts checked, %0d mismatches",
			max_modulus_offered, results_checked, mismatch_count);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
